// File: rtl/wshc_pkg.sv
// ----------------------------------------------------------------------------
// wshc_pkg
// Shared widths, register indexes, hint bundle and sideband types for the
// window size-hint constraint core.
// ----------------------------------------------------------------------------
package wshc_pkg;

  // Width of one window dimension.
  localparam int DIM_W = 16;
  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  // Divider operand widths: a 2*DIM_W product doubled plus a term, divided
  // by a doubled DIM_W value.
  localparam int PROD_W = 2 * DIM_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = DIM_W + 1;

  // One quotient bit per divider step, plus the divider's input register.
  localparam int DIV_STEPS = DIM_W;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam int FRONT_STAGES = 3;
  localparam int LIMIT_STAGES = 2;
  localparam int OUT_STAGES   = 1;
  localparam int LATENCY      = FRONT_STAGES + DIV_LAT + LIMIT_STAGES + DIV_LAT + OUT_STAGES;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FLAGS_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HONOR      = 3'd0,
    REG_FLAGS      = 3'd1,
    REG_BASE       = 3'd2,
    REG_MIN        = 3'd3,
    REG_MAX        = 3'd4,
    REG_INC        = 3'd5,
    REG_MIN_ASPECT = 3'd6,
    REG_MAX_ASPECT = 3'd7
  } cfg_reg_t;

  // Bit positions in hint_flags.
  localparam int FLAG_MIN    = 0;
  localparam int FLAG_MAX    = 1;
  localparam int FLAG_INC    = 2;
  localparam int FLAG_ASPECT = 3;
  localparam int FLAG_BASE   = 4;

  // Hints decoded from the configuration registers.
  typedef struct packed {
    logic             honor;
    logic             aspect_en;
    logic             max_en;
    logic             inc_en;
    logic [DIM_W-1:0] bw;
    logic [DIM_W-1:0] bh;
    logic [DIM_W-1:0] rbw;
    logic [DIM_W-1:0] rbh;
    logic [DIM_W-1:0] mw;
    logic [DIM_W-1:0] mh;
    logic [DIM_W-1:0] xw;
    logic [DIM_W-1:0] xh;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] mnn;
    logic [DIM_W-1:0] mnd;
    logic [DIM_W-1:0] mxn;
    logic [DIM_W-1:0] mxd;
  } hints_t;

  typedef enum logic [1:0] {
    ASP_NONE   = 2'd0,
    ASP_HEIGHT = 2'd1,
    ASP_WIDTH  = 2'd2
  } asp_mode_t;

  // Sideband carried through the aspect divider.
  typedef struct packed {
    asp_mode_t        mode;
    logic             byp;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } asp_side_t;

  // Sideband carried through each increment divider.
  typedef struct packed {
    logic             apply;
    logic [DIM_W-1:0] dim;
  } inc_side_t;

  localparam int TAG_W = $bits(asp_side_t);
  localparam int INC_SIDE_W = $bits(inc_side_t);

endpackage

// File: rtl/wshc_div.sv
// ----------------------------------------------------------------------------
// wshc_div
// Pipelined restoring divider: one quotient bit per stage. Quotients that do
// not fit in DIM_W bits are flagged as overflow. Carries a sideband tag.
// ----------------------------------------------------------------------------
module wshc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [wshc_pkg::NUM_W-1:0]  in_num,
  input  logic [wshc_pkg::DEN_W-1:0]  in_den,
  input  logic [wshc_pkg::TAG_W-1:0]  in_tag,
  output logic                        out_valid,
  output logic [wshc_pkg::DIM_W-1:0]  out_quot,
  output logic [wshc_pkg::DEN_W-1:0]  out_rem,
  output logic                        out_ovf,
  output logic [wshc_pkg::TAG_W-1:0]  out_tag
);

  localparam int STEPS = wshc_pkg::DIV_STEPS;
  localparam int DIM_W = wshc_pkg::DIM_W;
  localparam int DEN_W = wshc_pkg::DEN_W;
  localparam int NUM_W = wshc_pkg::NUM_W;

  logic                        vld_r  [0:STEPS];
  logic [DIM_W-1:0]            low_r  [0:STEPS];
  logic [DEN_W-1:0]            den_r  [0:STEPS];
  logic [DEN_W-1:0]            rem_r  [0:STEPS];
  logic [DIM_W-1:0]            quot_r [0:STEPS];
  logic                        ovf_r  [0:STEPS];
  logic [wshc_pkg::TAG_W-1:0]  tag_r  [0:STEPS];

  logic ovf_nxt;

  // The quotient fits in DIM_W bits exactly when the upper dividend part is
  // below the divisor; that part is then the starting partial remainder.
  assign ovf_nxt = (in_num[NUM_W-1:DIM_W] >= in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    low_r[0]  <= in_num[DIM_W-1:0];
    den_r[0]  <= in_den;
    ovf_r[0]  <= ovf_nxt;
    rem_r[0]  <= ovf_nxt ? '0 : in_num[NUM_W-1:DIM_W];
    quot_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {rem_r[i], low_r[i][DIM_W-1-i]};
    assign fits  = (trial >= {1'b0, den_r[i]});
    assign diff  = trial - {1'b0, den_r[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      low_r[i+1]  <= low_r[i];
      den_r[i+1]  <= den_r[i];
      ovf_r[i+1]  <= ovf_r[i];
      tag_r[i+1]  <= tag_r[i];
      rem_r[i+1]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_r[i+1] <= {quot_r[i][DIM_W-2:0], fits};
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_quot  = quot_r[STEPS];
  assign out_rem   = rem_r[STEPS];
  assign out_ovf   = ovf_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

// File: rtl/wshc_front.sv
// ----------------------------------------------------------------------------
// wshc_front
// Input register, aspect cross products and aspect branch selection. Feeds
// the rounding division that rebuilds the constrained dimension.
// ----------------------------------------------------------------------------
module wshc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [wshc_pkg::DIM_W-1:0]  in_w,
  input  logic [wshc_pkg::DIM_W-1:0]  in_h,
  input  logic                        in_fs,
  input  wshc_pkg::hints_t            hints,
  output logic                        div_valid,
  output logic [wshc_pkg::NUM_W-1:0]  div_num,
  output logic [wshc_pkg::DEN_W-1:0]  div_den,
  output logic [wshc_pkg::TAG_W-1:0]  div_tag
);

  localparam int DIM_W  = wshc_pkg::DIM_W;
  localparam int PROD_W = wshc_pkg::PROD_W;
  localparam int NUM_W  = wshc_pkg::NUM_W;

  // Stage 1: input register.
  logic             v1_r;
  logic [DIM_W-1:0] w1_r, h1_r;
  logic             byp1_r;

  // Stage 2: cross products.
  logic              v2_r;
  logic [DIM_W-1:0]  w2_r, h2_r;
  logic              byp2_r, asp2_r;
  logic [PROD_W-1:0] pa2_r, pb2_r, pc2_r, pd2_r;

  // Stage 3: division operands.
  logic                       v3_r;
  logic [NUM_W-1:0]           num3_r;
  logic [wshc_pkg::DEN_W-1:0] den3_r;
  wshc_pkg::asp_side_t        side3_r;

  logic [DIM_W-1:0]           dx, dy;
  logic                       asp_nxt;
  logic                       lt, gt;
  wshc_pkg::asp_mode_t        mode_nxt;
  logic [NUM_W-1:0]           num_nxt;
  logic [wshc_pkg::DEN_W-1:0] den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    w1_r   <= in_w;
    h1_r   <= in_h;
    byp1_r <= !hints.honor || in_fs;
  end

  assign dx = w1_r - hints.rbw;
  assign dy = h1_r - hints.rbh;
  assign asp_nxt = !byp1_r && hints.aspect_en && (w1_r > hints.rbw) && (h1_r > hints.rbh);

  always_ff @(posedge clk) begin
    w2_r   <= w1_r;
    h2_r   <= h1_r;
    byp2_r <= byp1_r;
    asp2_r <= asp_nxt;
    pa2_r  <= PROD_W'(dx) * PROD_W'(hints.mnd);
    pb2_r  <= PROD_W'(hints.mnn) * PROD_W'(dy);
    pc2_r  <= PROD_W'(dx) * PROD_W'(hints.mxd);
    pd2_r  <= PROD_W'(hints.mxn) * PROD_W'(dy);
  end

  assign lt = (pa2_r < pb2_r);
  assign gt = (pc2_r > pd2_r);

  // Too narrow for the minimum ratio: rebuild the height. Too wide for the
  // maximum ratio: rebuild the width. Adding half the divisor rounds half up.
  always_comb begin
    if (asp2_r && lt) begin
      mode_nxt = wshc_pkg::ASP_HEIGHT;
    end else if (asp2_r && gt) begin
      mode_nxt = wshc_pkg::ASP_WIDTH;
    end else begin
      mode_nxt = wshc_pkg::ASP_NONE;
    end
    case (mode_nxt)
      wshc_pkg::ASP_HEIGHT: begin
        num_nxt = {pa2_r, 1'b0} + NUM_W'(hints.mnn);
        den_nxt = {hints.mnn, 1'b0};
      end
      wshc_pkg::ASP_WIDTH: begin
        num_nxt = {pd2_r, 1'b0} + NUM_W'(hints.mxd);
        den_nxt = {hints.mxd, 1'b0};
      end
      default: begin
        num_nxt = '0;
        den_nxt = '1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    num3_r       <= num_nxt;
    den3_r       <= den_nxt;
    side3_r.mode <= mode_nxt;
    side3_r.byp  <= byp2_r;
    side3_r.w    <= w2_r;
    side3_r.h    <= h2_r;
  end

  assign div_valid = v3_r;
  assign div_num   = num3_r;
  assign div_den   = den3_r;
  assign div_tag   = side3_r;

endmodule

// File: rtl/wshc_limit.sv
// ----------------------------------------------------------------------------
// wshc_limit
// Applies the aspect result, then the minimum and maximum size, and prepares
// the offsets above the base size for the increment snapping.
// ----------------------------------------------------------------------------
module wshc_limit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [wshc_pkg::DIM_W-1:0]  in_quot,
  input  logic                        in_ovf,
  input  logic [wshc_pkg::TAG_W-1:0]  in_tag,
  input  wshc_pkg::hints_t            hints,
  output logic                        mod_valid,
  output logic [wshc_pkg::NUM_W-1:0]  mod_num_w,
  output logic [wshc_pkg::NUM_W-1:0]  mod_num_h,
  output logic [wshc_pkg::DEN_W-1:0]  mod_den_w,
  output logic [wshc_pkg::DEN_W-1:0]  mod_den_h,
  output logic [wshc_pkg::TAG_W-1:0]  mod_tag_w,
  output logic [wshc_pkg::TAG_W-1:0]  mod_tag_h
);

  localparam int DIM_W = wshc_pkg::DIM_W;
  localparam int NUM_W = wshc_pkg::NUM_W;
  localparam int DEN_W = wshc_pkg::DEN_W;
  localparam int TAG_W = wshc_pkg::TAG_W;

  wshc_pkg::asp_side_t side;
  logic [DIM_W-1:0]    rb;
  logic [DIM_W:0]      sum;
  logic [DIM_W-1:0]    aval;
  logic [DIM_W-1:0]    wa, ha;

  logic             v1_r, byp1_r;
  logic [DIM_W-1:0] w1_r, h1_r;
  logic [DIM_W-1:0] w1_nxt, h1_nxt;

  logic             v2_r;
  logic [DIM_W-1:0] w2, h2, tw, th;
  logic             apply;
  logic [NUM_W-1:0] num_w_r, num_h_r;
  logic [DEN_W-1:0] den_w_r, den_h_r;
  wshc_pkg::inc_side_t side_w_r, side_h_r;

  assign side = wshc_pkg::asp_side_t'(in_tag);
  assign rb   = (side.mode == wshc_pkg::ASP_WIDTH) ? hints.rbw : hints.rbh;
  assign sum  = {1'b0, in_quot} + {1'b0, rb};
  assign aval = (in_ovf || sum[DIM_W]) ? wshc_pkg::DIM_MAX : sum[DIM_W-1:0];

  always_comb begin
    wa = side.w;
    ha = side.h;
    case (side.mode)
      wshc_pkg::ASP_HEIGHT: ha = aval;
      wshc_pkg::ASP_WIDTH:  wa = aval;
      default: ;
    endcase
    w1_nxt = wa;
    h1_nxt = ha;
    if (!side.byp) begin
      if (wa < hints.mw) w1_nxt = hints.mw;
      if (ha < hints.mh) h1_nxt = hints.mh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    w1_r   <= w1_nxt;
    h1_r   <= h1_nxt;
    byp1_r <= side.byp;
  end

  // A zero maximum on an axis means that axis has no limit.
  assign w2 = (!byp1_r && hints.max_en && (hints.xw != '0) && (w1_r > hints.xw)) ?
              hints.xw : w1_r;
  assign h2 = (!byp1_r && hints.max_en && (hints.xh != '0) && (h1_r > hints.xh)) ?
              hints.xh : h1_r;
  assign tw = (w2 > hints.bw) ? w2 - hints.bw : '0;
  assign th = (h2 > hints.bh) ? h2 - hints.bh : '0;
  assign apply = !byp1_r && hints.inc_en;

  always_ff @(posedge clk) begin
    num_w_r        <= NUM_W'(tw);
    num_h_r        <= NUM_W'(th);
    den_w_r        <= DEN_W'(hints.iw);
    den_h_r        <= DEN_W'(hints.ih);
    side_w_r.apply <= apply;
    side_w_r.dim   <= w2;
    side_h_r.apply <= apply;
    side_h_r.dim   <= h2;
  end

  assign mod_valid = v2_r;
  assign mod_num_w = num_w_r;
  assign mod_num_h = num_h_r;
  assign mod_den_w = den_w_r;
  assign mod_den_h = den_h_r;
  assign mod_tag_w = TAG_W'(side_w_r);
  assign mod_tag_h = TAG_W'(side_h_r);

endmodule

// File: rtl/window_size_hint_constrain_core.sv
// ----------------------------------------------------------------------------
// window_size_hint_constrain_core
// Constrains a requested window size by size hints held in configuration.
// ----------------------------------------------------------------------------
// Usage: the core takes one request in every clock cycle while busy is low
// and delivers each result (out_valid high for one cycle) in request order.
// The pipeline holds 16-step pipelined dividers in series: one rounds the
// aspect-ratio correction, then a pair, one per axis, finds the remainders
// for increment snapping. busy is set during reset, cleared at the first
// clock edge after reset is released, and low otherwise. The output cannot
// be held off, so a result must be captured in the cycle it is shown. Hint
// registers must only be written while no request is in flight.
module window_size_hint_constrain_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [15:0]                     in_req_width,
  input  logic [15:0]                     in_req_height,
  input  logic                            in_fullscreen,
  output logic                            out_valid,
  output logic [15:0]                     out_width,
  output logic [15:0]                     out_height,
  input  logic                            cfg_we,
  input  logic [wshc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wshc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DIM_W = wshc_pkg::DIM_W;
  localparam int NUM_W = wshc_pkg::NUM_W;
  localparam int DEN_W = wshc_pkg::DEN_W;
  localparam int TAG_W = wshc_pkg::TAG_W;

  logic                          busy_r;
  logic                          honor_r;
  logic [wshc_pkg::FLAGS_W-1:0]  flags_r;
  logic [wshc_pkg::CFG_W-1:0]    base_r, min_r, max_r, inc_r, mina_r, maxa_r;
  wshc_pkg::hints_t              hints;

  logic             acc;
  logic             d1_valid, d1_ovf;
  logic [NUM_W-1:0] d1_num;
  logic [DEN_W-1:0] d1_den, d1_rem;
  logic [TAG_W-1:0] d1_tag, d1_tag_out;
  logic [DIM_W-1:0] d1_quot;

  logic             m_valid;
  logic [NUM_W-1:0] m_num_w, m_num_h;
  logic [DEN_W-1:0] m_den_w, m_den_h;
  logic [TAG_W-1:0] m_tag_w, m_tag_h;

  logic             rw_valid, rh_valid, rw_ovf, rh_ovf;
  logic [DIM_W-1:0] rw_quot, rh_quot;
  logic [DEN_W-1:0] rw_rem, rh_rem;
  logic [TAG_W-1:0] rw_tag, rh_tag;
  wshc_pkg::inc_side_t side_w, side_h;

  logic             out_valid_r;
  logic [DIM_W-1:0] out_width_r, out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      honor_r <= 1'b0;
      flags_r <= '0;
      base_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      inc_r   <= '0;
      mina_r  <= '0;
      maxa_r  <= '0;
    end else if (cfg_we) begin
      unique case (wshc_pkg::cfg_reg_t'(cfg_index))
        wshc_pkg::REG_HONOR:      honor_r <= cfg_data[0];
        wshc_pkg::REG_FLAGS:      flags_r <= cfg_data[wshc_pkg::FLAGS_W-1:0];
        wshc_pkg::REG_BASE:       base_r  <= cfg_data;
        wshc_pkg::REG_MIN:        min_r   <= cfg_data;
        wshc_pkg::REG_MAX:        max_r   <= cfg_data;
        wshc_pkg::REG_INC:        inc_r   <= cfg_data;
        wshc_pkg::REG_MIN_ASPECT: mina_r  <= cfg_data;
        wshc_pkg::REG_MAX_ASPECT: maxa_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Base falls back to min and min falls back to base. Only a real base size
  // offsets the aspect ratio.
  always_comb begin
    hints.honor = honor_r;
    hints.rbw   = flags_r[wshc_pkg::FLAG_BASE] ? base_r[DIM_W-1:0] : '0;
    hints.rbh   = flags_r[wshc_pkg::FLAG_BASE] ? base_r[2*DIM_W-1:DIM_W] : '0;
    if (flags_r[wshc_pkg::FLAG_BASE]) begin
      hints.bw = base_r[DIM_W-1:0];
      hints.bh = base_r[2*DIM_W-1:DIM_W];
    end else if (flags_r[wshc_pkg::FLAG_MIN]) begin
      hints.bw = min_r[DIM_W-1:0];
      hints.bh = min_r[2*DIM_W-1:DIM_W];
    end else begin
      hints.bw = '0;
      hints.bh = '0;
    end
    if (flags_r[wshc_pkg::FLAG_MIN]) begin
      hints.mw = min_r[DIM_W-1:0];
      hints.mh = min_r[2*DIM_W-1:DIM_W];
    end else if (flags_r[wshc_pkg::FLAG_BASE]) begin
      hints.mw = base_r[DIM_W-1:0];
      hints.mh = base_r[2*DIM_W-1:DIM_W];
    end else begin
      hints.mw = '0;
      hints.mh = '0;
    end
    hints.xw  = max_r[DIM_W-1:0];
    hints.xh  = max_r[2*DIM_W-1:DIM_W];
    hints.iw  = inc_r[DIM_W-1:0];
    hints.ih  = inc_r[2*DIM_W-1:DIM_W];
    hints.mnn = mina_r[DIM_W-1:0];
    hints.mnd = mina_r[2*DIM_W-1:DIM_W];
    hints.mxn = maxa_r[DIM_W-1:0];
    hints.mxd = maxa_r[2*DIM_W-1:DIM_W];
    hints.max_en = flags_r[wshc_pkg::FLAG_MAX];
    hints.aspect_en = flags_r[wshc_pkg::FLAG_ASPECT] &&
                      (hints.mnn != '0) && (hints.mnd != '0) &&
                      (hints.mxn != '0) && (hints.mxd != '0);
    hints.inc_en = (flags_r[wshc_pkg::FLAG_INC] || flags_r[wshc_pkg::FLAG_BASE]) &&
                   (hints.iw != '0) && (hints.ih != '0);
  end

  wshc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_w      (in_req_width),
    .in_h      (in_req_height),
    .in_fs     (in_fullscreen),
    .hints     (hints),
    .div_valid (d1_valid),
    .div_num   (d1_num),
    .div_den   (d1_den),
    .div_tag   (d1_tag)
  );

  logic             a_valid;

  wshc_div u_div_aspect (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_num    (d1_num),
    .in_den    (d1_den),
    .in_tag    (d1_tag),
    .out_valid (a_valid),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_ovf   (d1_ovf),
    .out_tag   (d1_tag_out)
  );

  wshc_limit u_limit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_quot   (d1_quot),
    .in_ovf    (d1_ovf),
    .in_tag    (d1_tag_out),
    .hints     (hints),
    .mod_valid (m_valid),
    .mod_num_w (m_num_w),
    .mod_num_h (m_num_h),
    .mod_den_w (m_den_w),
    .mod_den_h (m_den_h),
    .mod_tag_w (m_tag_w),
    .mod_tag_h (m_tag_h)
  );

  wshc_div u_div_inc_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_num    (m_num_w),
    .in_den    (m_den_w),
    .in_tag    (m_tag_w),
    .out_valid (rw_valid),
    .out_quot  (rw_quot),
    .out_rem   (rw_rem),
    .out_ovf   (rw_ovf),
    .out_tag   (rw_tag)
  );

  wshc_div u_div_inc_h (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_num    (m_num_h),
    .in_den    (m_den_h),
    .in_tag    (m_tag_h),
    .out_valid (rh_valid),
    .out_quot  (rh_quot),
    .out_rem   (rh_rem),
    .out_ovf   (rh_ovf),
    .out_tag   (rh_tag)
  );

  assign side_w = wshc_pkg::inc_side_t'(rw_tag[wshc_pkg::INC_SIDE_W-1:0]);
  assign side_h = wshc_pkg::inc_side_t'(rh_tag[wshc_pkg::INC_SIDE_W-1:0]);

  // The aspect remainder, the increment quotients and the overflow flags of
  // the increment dividers are not needed: the offsets there are below the
  // divisor's range. Snapping removes only the remainder.
  logic unused_ok;
  assign unused_ok = ^{d1_rem, rw_quot, rh_quot, rw_ovf, rh_ovf};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rw_valid && rh_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_width_r  <= side_w.apply ? side_w.dim - rw_rem[DIM_W-1:0] : side_w.dim;
    out_height_r <= side_h.apply ? side_h.dim - rh_rem[DIM_W-1:0] : side_h.dim;
  end

  assign out_valid  = out_valid_r;
  assign out_width  = out_width_r;
  assign out_height = out_height_r;

endmodule

// File: rtl/wshc_checker.sv
// ----------------------------------------------------------------------------
// wshc_checker
// Port-level checks on the constraint core: fixed latency, one result per
// accepted beat, fullscreen pass-through and busy during reset.
// ----------------------------------------------------------------------------
module wshc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_req_width,
  input logic [15:0] in_req_height,
  input logic        in_fullscreen,
  input logic        out_valid,
  input logic [15:0] out_width,
  input logic [15:0] out_height
);

  // Every accepted beat produces a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(wshc_pkg::LATENCY) out_valid)
    else $error("accepted beat produced no result");

  // No result appears without a beat accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, wshc_pkg::LATENCY))
    else $error("result without matching beat");

  // Fullscreen requests come back unchanged.
  a_fullscreen_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_fullscreen) |-> ##(wshc_pkg::LATENCY)
      ((out_width == $past(in_req_width, wshc_pkg::LATENCY)) &&
       (out_height == $past(in_req_height, wshc_pkg::LATENCY))))
    else $error("fullscreen request was altered");

  // Nothing is taken while the core comes out of reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

endmodule

bind window_size_hint_constrain_core wshc_checker u_wshc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_req_width  (in_req_width),
  .in_req_height (in_req_height),
  .in_fullscreen (in_fullscreen),
  .out_valid     (out_valid),
  .out_width     (out_width),
  .out_height    (out_height)
);
